// ===== sv/frgn_pkg.sv =====
// ----------------------------------------------------------------------------
// frgn_pkg
// shared types and constants of the fixed-radius grid neighbor search core
// ----------------------------------------------------------------------------
package frgn_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int MAX_NEIGHBORS = 64;
    localparam int COORD_WIDTH   = 32;

    localparam int XW = 32;   // coordinate field width
    localparam int RW = 31;   // radius width
    localparam int IW = 10;   // result index width

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    typedef logic [1:0] t_req;
    localparam t_req REQ_CLEAR  = 2'd0;
    localparam t_req REQ_INSERT = 2'd1;
    localparam t_req REQ_QUERY  = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_TRUNC     = 3'd2;
    localparam t_status ST_NONE      = 3'd3;
    localparam t_status ST_CLEARED   = 3'd4;

endpackage

// ===== sv/frgn_if.sv =====
// ----------------------------------------------------------------------------
// frgn interfaces
// request, result and radius configuration channels
// ----------------------------------------------------------------------------
interface frgn_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    modport source (output valid, req_type, point_x, point_y, input ready);
    modport sink (input valid, req_type, point_x, point_y, output ready);
endinterface

interface frgn_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [9:0] index;
    logic       last;
    modport source (output valid, status, index, last, input ready);
    modport sink (input valid, status, index, last, output ready);
endinterface

interface frgn_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] radius;
    modport source (output valid, radius, input ready);
    modport sink (input valid, radius, output ready);
endinterface

// ===== sv/frgn_ram.sv =====
// ----------------------------------------------------------------------------
// frgn_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module frgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/fixed_radius_grid_neighbor_search_core.sv =====
// ----------------------------------------------------------------------------
// fixed_radius_grid_neighbor_search_core
// point table with grid binning and 3x3 cell fixed-radius neighbor query
// ----------------------------------------------------------------------------
//  channel  | dir | fields                          | transaction
//  i_req    | in  | req_type, point_x, point_y      | valid & ready
//  o_rsp    | out | status, index, last             | valid & ready
//  i_cfg    | in  | radius                          | valid & ready
//
//  clear goes straight to its result; insert runs two divides (x, then y)
//  query runs the same divides, squares the radius, then scans every point for each
//  of the 9 cells, with two squarings per point whose cell matches and that passes
//  the box test; built on a single-bit restoring divider, a shift-add multiplier
//  and a scan that reads the point ram once per pass through S_ADV, S_RD and S_CHK
//  reset clears point count and sets radius to RADIUS_RESET; ram contents need no clearing
//  a stalled result slot holds the scan; ready is low while an item runs
// ----------------------------------------------------------------------------
module fixed_radius_grid_neighbor_search_core #(
    parameter int MAX_POINTS    = frgn_pkg::MAX_POINTS,
    parameter int MAX_NEIGHBORS = frgn_pkg::MAX_NEIGHBORS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frgn_req_if.sink   i_req,
    frgn_rsp_if.source o_rsp,
    frgn_cfg_if.sink   i_cfg
);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = PW + 1;
    localparam int KW = $clog2(MAX_NEIGHBORS + 1);
    localparam int SH = frgn_pkg::XW - frgn_pkg::COORD_WIDTH;
    localparam int DW = 4 * frgn_pkg::XW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_DIVF  = 4'd2;
    localparam logic [3:0] S_WRITE = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_HIT   = 4'd7;
    localparam logic [3:0] S_ADV   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // multiplier job codes
    localparam logic [1:0] M_R2 = 2'd0;
    localparam logic [1:0] M_DX = 2'd1;
    localparam logic [1:0] M_DY = 2'd2;

    logic [3:0]              r_state;
    logic [30:0]             r_radius;
    logic [CW-1:0]           r_count;
    logic                    r_query;
    logic signed [31:0]      r_qx, r_qy, r_cx, r_cy;
    // divider
    logic                    r_div_y, r_div_neg;
    logic [4:0]              r_div_cnt;
    logic [31:0]             r_div_q;
    logic [30:0]             r_div_rem;
    // multiplier
    logic [1:0]              r_mjob;
    logic [4:0]              r_mcnt;
    logic [30:0]             r_mplier;
    logic [61:0]             r_mcand;
    logic [63:0]             r_acc;
    logic [61:0]             r_r2;
    logic [30:0]             r_ady;
    // scan
    logic [1:0]              r_gx, r_gy;
    logic [PW-1:0]           r_i;
    logic                    r_have_pend;
    logic [PW-1:0]           r_pend;
    logic [KW-1:0]           r_k;
    logic                    r_done_trunc;
    // pending single result and output slot
    logic [2:0]              r_res_status;
    logic [9:0]              r_res_index;
    logic                    r_ov;
    logic [2:0]              r_o_status;
    logic [9:0]              r_o_index;
    logic                    r_o_last;

    logic [30:0] eff_r;
    logic        slot_free;
    logic        take;
    logic signed [31:0] in_x, in_y;
    logic [DW-1:0] rd_data;
    logic signed [31:0] sp_x, sp_y, sc_x, sc_y;
    logic signed [33:0] tgt_x, tgt_y;
    logic signed [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic [31:0] div_mag;
    logic [31:0] rem_sh;
    logic [31:0] div_cell;
    logic        last_i;
    logic        we;

    assign eff_r     = (r_radius == '0) ? 31'd1 : r_radius;
    assign slot_free = !r_ov || o_rsp.ready;
    assign take      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // low coord_width bits, sign extended
    assign in_x = $signed(i_req.point_x <<< SH) >>> SH;
    assign in_y = $signed(i_req.point_y <<< SH) >>> SH;

    assign we = (r_state == S_WRITE);

    frgn_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[PW-1:0]),
        .i_wdata ({r_qx, r_qy, r_cx, r_cy}),
        .i_raddr (r_i),
        .o_rdata (rd_data)
    );

    assign sp_x = rd_data[127:96];
    assign sp_y = rd_data[95:64];
    assign sc_x = rd_data[63:32];
    assign sc_y = rd_data[31:0];

    // cell under test: own cell plus offset gx-1, gy-1
    assign tgt_x = 34'(r_cx) + $signed({32'd0, r_gx}) - 34'sd1;
    assign tgt_y = 34'(r_cy) + $signed({32'd0, r_gy}) - 34'sd1;

    assign dx  = 33'(sp_x) - 33'(r_qx);
    assign dy  = 33'(sp_y) - 33'(r_qy);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);

    // restoring divide step
    assign div_mag = r_qy;   // y operand, loaded once the x divide is done
    assign rem_sh  = {r_div_rem, r_div_q[31]};
    // floor quotient from magnitude quotient and remainder
    assign div_cell = !r_div_neg ? r_div_q :
                      (r_div_rem != '0) ? ~r_div_q : 32'(-r_div_q);

    assign last_i = (32'(r_i) == 32'(r_count) - 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_radius     <= frgn_pkg::RADIUS_RESET;
            r_count      <= '0;
            r_ov         <= 1'b0;
            r_done_trunc <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_radius <= i_cfg.radius;
            end
            if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_qx      <= in_x;
                        r_qy      <= in_y;
                        r_query   <= (i_req.req_type == frgn_pkg::REQ_QUERY);
                        r_div_y   <= 1'b0;
                        r_div_neg <= in_x[31];
                        r_div_q   <= in_x[31] ? 32'(-in_x) : in_x;
                        r_div_rem <= '0;
                        r_div_cnt <= '0;
                        case (i_req.req_type)
                            frgn_pkg::REQ_CLEAR: begin
                                r_count      <= '0;
                                r_res_status <= frgn_pkg::ST_CLEARED;
                                r_res_index  <= '0;
                                r_state      <= S_OUT;
                            end
                            frgn_pkg::REQ_INSERT: begin
                                if (r_count == CW'(MAX_POINTS)) begin
                                    r_res_status <= frgn_pkg::ST_FULL;
                                    r_res_index  <= '0;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            frgn_pkg::REQ_QUERY: begin
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, eff_r}) begin
                        r_div_rem <= 31'(rem_sh - {1'b0, eff_r});
                        r_div_q   <= {r_div_q[30:0], 1'b1};
                    end else begin
                        r_div_rem <= rem_sh[30:0];
                        r_div_q   <= {r_div_q[30:0], 1'b0};
                    end
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd31) begin
                        r_state <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    if (!r_div_y) begin
                        r_cx      <= div_cell;
                        r_div_y   <= 1'b1;
                        r_div_neg <= r_qy[31];
                        r_div_q   <= r_qy[31] ? 32'(-div_mag) : div_mag;
                        r_div_rem <= '0;
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end else begin
                        r_cy <= div_cell;
                        if (r_query) begin
                            r_mjob   <= M_R2;
                            r_acc    <= '0;
                            r_mplier <= eff_r;
                            r_mcand  <= 62'(eff_r);
                            r_mcnt   <= '0;
                            r_state  <= S_MUL;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_res_status <= frgn_pkg::ST_OK;
                    r_res_index  <= 10'(r_count);
                    r_count      <= r_count + CW'(1);
                    r_state      <= S_OUT;
                end
                S_MUL: begin
                    // shift-add squaring, one multiplier bit per cycle
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + 64'(r_mcand);
                    end
                    r_mplier <= r_mplier >> 1;
                    r_mcand  <= r_mcand << 1;
                    r_mcnt   <= r_mcnt + 5'd1;
                    if (r_mcnt == 5'd30) begin
                        case (r_mjob)
                            M_R2: begin
                                r_state <= S_FIN;
                            end
                            M_DX: begin
                                r_mjob   <= M_DY;
                                r_mplier <= r_ady;
                                r_mcand  <= 62'(r_ady);
                                r_mcnt   <= '0;
                                r_state  <= S_MUL;
                            end
                            default: begin
                                r_state <= S_CHK;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_mjob == M_DY) begin
                        // both squares summed: compare with radius squared
                        r_mjob  <= M_R2;
                        r_state <= (r_acc <= 64'(r_r2)) ? S_HIT : S_ADV;
                    end else if (34'(sc_x) != tgt_x || 34'(sc_y) != tgt_y) begin
                        r_state <= S_ADV;
                    end else if (adx > 33'(eff_r) || ady > 33'(eff_r)) begin
                        r_state <= S_ADV;
                    end else begin
                        r_ady    <= ady[30:0];
                        r_mjob   <= M_DX;
                        r_acc    <= '0;
                        r_mplier <= adx[30:0];
                        r_mcand  <= 62'(adx[30:0]);
                        r_mcnt   <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_HIT: begin
                    if (!r_have_pend) begin
                        r_have_pend <= 1'b1;
                        r_pend      <= r_i;
                        r_k         <= KW'(1);
                        r_state     <= S_ADV;
                    end else if (slot_free) begin
                        r_ov       <= 1'b1;
                        r_o_index  <= 10'(r_pend);
                        if (r_k == KW'(MAX_NEIGHBORS)) begin
                            // one match too many: close the list truncated
                            r_o_status <= frgn_pkg::ST_TRUNC;
                            r_o_last   <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_o_status <= frgn_pkg::ST_OK;
                            r_o_last   <= 1'b0;
                            r_pend     <= r_i;
                            r_k        <= r_k + KW'(1);
                            r_state    <= S_ADV;
                        end
                    end
                end
                S_ADV: begin
                    r_state <= S_RD;
                    if (last_i) begin
                        r_i <= '0;
                        r_gy <= r_gy + 2'd1;
                        if (r_gy == 2'd2) begin
                            r_gy <= '0;
                            r_gx <= r_gx + 2'd1;
                            if (r_gx == 2'd2) begin
                                r_done_trunc <= 1'b1;
                                r_state      <= S_FIN;
                            end
                        end
                    end else begin
                        r_i <= r_i + PW'(1);
                    end
                end
                S_FIN: begin
                    if (r_mjob == M_R2 && !r_done_trunc && r_state == S_FIN
                        && r_mcnt == 5'd31) begin
                        // radius squared ready: start the scan
                        r_r2        <= r_acc[61:0];
                        r_mcnt      <= '0;
                        r_gx        <= '0;
                        r_gy        <= '0;
                        r_i         <= '0;
                        r_have_pend <= 1'b0;
                        r_k         <= '0;
                        r_state     <= (r_count == '0) ? S_FIN : S_RD;
                        r_done_trunc <= (r_count == '0);
                    end else begin
                        // scan finished: emit closing result
                        r_res_status <= r_have_pend ? frgn_pkg::ST_OK : frgn_pkg::ST_NONE;
                        r_res_index  <= r_have_pend ? 10'(r_pend) : 10'd0;
                        r_done_trunc <= 1'b0;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_index  <= r_res_index;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid  = r_ov;
    assign o_rsp.status = r_o_status;
    assign o_rsp.index  = r_o_index;
    assign o_rsp.last   = r_o_last;
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the fixed-radius grid neighbor search core;
// a local model of the point table predicts every result transaction,
// which the monitor checks in order against the core's output
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam frgn_pkg::t_req REQ_UNUSED = 2'd3;

    typedef struct packed {
        frgn_pkg::t_req req;
        logic [31:0]    x;
        logic [31:0]    y;
    } t_item;

    typedef struct packed {
        frgn_pkg::t_status status;
        logic [9:0]        index;
        logic              last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    frgn_req_if req_ch();
    frgn_rsp_if rsp_ch();
    frgn_cfg_if cfg_ch();

    fixed_radius_grid_neighbor_search_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- point table model ----------------
    logic signed [31:0] tbl_x [frgn_pkg::MAX_POINTS];
    logic signed [31:0] tbl_y [frgn_pkg::MAX_POINTS];
    longint             tbl_cx [frgn_pkg::MAX_POINTS];
    longint             tbl_cy [frgn_pkg::MAX_POINTS];
    int                 tbl_count = 0;
    logic [30:0]        cur_radius = frgn_pkg::RADIUS_RESET;

    t_item   pending_items [$];
    t_result expected_results [$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;      // long receiver hold-off request
    int hold_left = 0;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic void push_result(frgn_pkg::t_status st, int idx, bit lst);
        t_result r;
        r.status = st;
        r.index = idx[9:0];
        r.last = lst;
        expected_results = {expected_results, r};
    endfunction

    // expected results of one accepted request
    function automatic void predict_request(t_item it);
        longint r, qx, qy, cx, cy, dx, dy, r2;
        longint gx, gy;
        int k;
        bit trunc;
        r = (cur_radius == 0) ? 1 : longint'(cur_radius);
        qx = longint'($signed(it.x));
        qy = longint'($signed(it.y));
        cx = floor_div(qx, r);
        cy = floor_div(qy, r);
        r2 = r * r;
        k = 0;
        trunc = 1'b0;
        case (it.req)
            frgn_pkg::REQ_CLEAR: begin
                tbl_count = 0;
                push_result(frgn_pkg::ST_CLEARED, 0, 1'b1);
            end
            frgn_pkg::REQ_INSERT: begin
                if (tbl_count >= frgn_pkg::MAX_POINTS) begin
                    push_result(frgn_pkg::ST_FULL, 0, 1'b1);
                end else begin
                    tbl_x[tbl_count] = it.x;
                    tbl_y[tbl_count] = it.y;
                    tbl_cx[tbl_count] = cx;
                    tbl_cy[tbl_count] = cy;
                    push_result(frgn_pkg::ST_OK, tbl_count, 1'b1);
                    tbl_count++;
                end
            end
            frgn_pkg::REQ_QUERY: begin
                for (gx = cx - 1; gx <= cx + 1 && !trunc; gx++)
                    for (gy = cy - 1; gy <= cy + 1 && !trunc; gy++)
                        for (int i = 0; i < tbl_count; i++) begin
                            if (tbl_cx[i] != gx || tbl_cy[i] != gy) continue;
                            dx = longint'(tbl_x[i]) - qx;
                            dy = longint'(tbl_y[i]) - qy;
                            if (dx < 0) dx = -dx;
                            if (dy < 0) dy = -dy;
                            // beyond the radius on one axis: out of range
                            if (dx > r || dy > r) continue;
                            if ((dx * dx + dy * dy) > r2) continue;
                            if (k >= frgn_pkg::MAX_NEIGHBORS) begin
                                trunc = 1'b1;
                                break;
                            end
                            push_result(frgn_pkg::ST_OK, i, 1'b0);
                            k++;
                        end
                if (k == 0) begin
                    push_result(frgn_pkg::ST_NONE, 0, 1'b1);
                end else begin
                    expected_results[$].last = 1'b1;
                    if (trunc) expected_results[$].status = frgn_pkg::ST_TRUNC;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------- request driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_request('{req_ch.req_type, req_ch.point_x, req_ch.point_y});
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_item it;
                    it = pending_items.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= it.req;
                    req_ch.point_x <= it.x;
                    req_ch.point_y <= it.y;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(12, 0);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 0);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result receiver and checker ----------------
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                t_result got, want;
                got = '{rsp_ch.status, rsp_ch.index, rsp_ch.last};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d index=%0d last=%0d",
                                 got.status, got.index, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.index, want.last,
                                     got.status, got.index, got.last);
                    end
                end
            end
            // long hold-off, counted here
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 3000;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            // own stall pattern: runs of ready and of stall
            stall_phase = (stall_phase + 1) % 23;
            rsp_ch.ready <= (hold_left == 0) &&
                            (stall_phase < 14 || $urandom_range(1, 0) == 1);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || (hold_left > 0) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("fixed_radius_grid_neighbor_search_core: mismatch");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_item mk(frgn_pkg::t_req r, logic [31:0] x, logic [31:0] y);
        t_item it;
        it.req = r;
        it.x = x;
        it.y = y;
        return it;
    endfunction

    function automatic void add_item(t_item it);
        pending_items = {pending_items, it};
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || req_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);   // unused codes may still be in flight
    endtask

    task automatic write_radius(logic [30:0] r);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.radius <= r;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cur_radius = r;
        cfg_ch.valid <= 1'b0;
    endtask

    // random clustered points around the origin of a cell scale
    function automatic logic [31:0] near(int span);
        int v;
        v = $urandom_range(2 * span, 0) - span;
        return v;
    endfunction

    task automatic random_phase(int n, int span);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(19, 0);
            if (pick == 0)
                add_item(mk(frgn_pkg::REQ_CLEAR, $urandom, $urandom));
            else if (pick == 1)
                add_item(mk(REQ_UNUSED, $urandom, $urandom));
            else if (pick == 2)
                add_item(mk(frgn_pkg::t_req'($urandom_range(2, 1)), $urandom, $urandom));
            else if (pick < 12)
                add_item(mk(frgn_pkg::REQ_INSERT, near(span), near(span)));
            else
                add_item(mk(frgn_pkg::REQ_QUERY, near(span), near(span)));
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.point_x = '0;
        req_ch.point_y = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.radius = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request, empty query, full-range points
        add_item(mk(frgn_pkg::REQ_QUERY, 32'd0, 32'd0));
        add_item(mk(frgn_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h8000_0000));
        add_item(mk(frgn_pkg::REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff));
        add_item(mk(frgn_pkg::REQ_INSERT, 32'd0, 32'd0));
        add_item(mk(frgn_pkg::REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff));
        add_item(mk(frgn_pkg::REQ_INSERT, 32'h0001_0000, 32'd0));
        add_item(mk(frgn_pkg::REQ_QUERY, 32'd0, 32'd0));
        add_item(mk(frgn_pkg::REQ_QUERY, 32'h7fff_ffff, 32'h8000_0000));
        add_item(mk(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
        add_item(mk(frgn_pkg::REQ_CLEAR, 32'd0, 32'd0));
        add_item(mk(frgn_pkg::REQ_QUERY, 32'd0, 32'd0));
        wait_drained();

        // truncation: 66 points near the origin; receiver held off meanwhile
        write_radius(31'h7fff_ffff);
        hold_req = 1'b1;
        for (int i = 0; i < 66; i++)
            add_item(mk(frgn_pkg::REQ_INSERT, near(1000), near(1000)));
        add_item(mk(frgn_pkg::REQ_QUERY, 32'd0, 32'd0));
        wait_drained();

        // zero radius, then a pause until drained with radius one unit
        write_radius(31'd0);
        add_item(mk(frgn_pkg::REQ_CLEAR, 32'd0, 32'd0));
        random_phase(5, 3);
        wait_drained();

        write_radius(31'd1);
        add_item(mk(frgn_pkg::REQ_CLEAR, 32'd0, 32'd0));
        random_phase(4, 4);
        wait_drained();

        write_radius(frgn_pkg::RADIUS_RESET);
        add_item(mk(frgn_pkg::REQ_CLEAR, 32'd0, 32'd0));
        random_phase(8, 200000);
        wait_drained();

        write_radius(31'($urandom));
        random_phase(5, 32'h7fff_0000);
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("fixed_radius_grid_neighbor_search_core: match");
        else
            $display("fixed_radius_grid_neighbor_search_core: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/frgn_pkg.sv
sv/frgn_if.sv
sv/frgn_ram.sv
sv/fixed_radius_grid_neighbor_search_core.sv
bench/tb_top.sv
